>>> rtl/core/utf8_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// utf8_stream_decoder_assert.svh
// Assertion macros shared by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked out of reset only.
`define U8SD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every edge, reset included.
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define U8SD_ASSERT(lbl, prop, msg)
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/core/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Types, constants and lead-byte decode shared by the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam logic [15:0] REPLACEMENT = 16'hfffd;
    localparam logic [20:0] CODE_LIMIT  = 21'h10000;
    localparam logic [7:0]  ASCII_END   = 8'h80;
    localparam logic [7:0]  LEAD2_FIRST = 8'hc2;
    localparam logic [7:0]  LEAD3_FIRST = 8'he0;
    localparam logic [7:0]  LEAD4_FIRST = 8'hf0;
    localparam logic [7:0]  LEAD_END    = 8'hf5;
    localparam logic [1:0]  CONT_TAG    = 2'b10;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic [20:0] part_t;

    typedef struct packed {
        logic        emit;
        logic [15:0] code;
        logic [1:0]  pend;
        part_t       part;
    } lead_t;

    typedef struct packed {
        logic [1:0]  count;
        logic [15:0] code0;
        logic        last0;
        logic [15:0] code1;
    } dec_res_t;

    function automatic lead_t take_lead(input logic [7:0] c);
        lead_t r;
        r.emit = 1'b1;
        r.code = REPLACEMENT;
        r.pend = 2'd0;
        r.part = '0;
        if (c < ASCII_END) begin
            r.code = {8'h00, c};
        end else if (c < LEAD2_FIRST || c >= LEAD_END) begin
            r.code = REPLACEMENT;
        end else if (c < LEAD3_FIRST) begin
            r.emit = 1'b0;
            r.pend = 2'd1;
            r.part = {16'h0000, c[4:0]};
        end else if (c < LEAD4_FIRST) begin
            r.emit = 1'b0;
            r.pend = 2'd2;
            r.part = {17'h00000, c[3:0]};
        end else begin
            r.emit = 1'b0;
            r.pend = 2'd3;
            r.part = {18'h00000, c[2:0]};
        end
        return r;
    endfunction

    function automatic logic [15:0] clip_code(input part_t code);
        return (code < CODE_LIMIT) ? code[15:0] : REPLACEMENT;
    endfunction

endpackage

>>> rtl/core/utf8sd_decode.sv
// ----------------------------------------------------------------------------
// utf8sd_decode
// Sequence state and per-byte decode into zero, one or two results.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_assert.svh"

module utf8sd_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [7:0]          in_byte,
    output utf8sd_pkg::dec_res_t res
);

    logic [1:0]             bytes_pending_reg, bytes_pending_next;
    utf8sd_pkg::part_t      partial_code_reg, partial_code_next;
    utf8sd_pkg::lead_t      lead;
    utf8sd_pkg::part_t      shifted;

    assign lead    = utf8sd_pkg::take_lead(in_byte);
    assign shifted = {partial_code_reg[14:0], in_byte[5:0]};

    always_comb begin
        bytes_pending_next = bytes_pending_reg;
        partial_code_next  = partial_code_reg;
        res.count = 2'd0;
        res.code0 = lead.code;
        res.last0 = 1'b1;
        res.code1 = lead.code;
        if (bytes_pending_reg == 2'd0) begin
            if (lead.emit) begin
                res.count = 2'd1;
            end else begin
                bytes_pending_next = lead.pend;
                partial_code_next  = lead.part;
            end
        end else if (in_byte == 8'h00) begin
            res.count          = 2'd1;
            res.code0          = utf8sd_pkg::clip_code(partial_code_reg);
            bytes_pending_next = 2'd0;
            partial_code_next  = '0;
        end else if (in_byte[7:6] == utf8sd_pkg::CONT_TAG) begin
            bytes_pending_next = 2'(bytes_pending_reg - 2'd1);
            partial_code_next  = shifted;
            if (bytes_pending_reg == 2'd1) begin
                res.count         = 2'd1;
                res.code0         = utf8sd_pkg::clip_code(shifted);
                partial_code_next = '0;
            end
        end else begin
            res.code0          = utf8sd_pkg::REPLACEMENT;
            bytes_pending_next = lead.emit ? 2'd0 : lead.pend;
            partial_code_next  = lead.emit ? '0 : lead.part;
            if (lead.emit) begin
                res.count = 2'd2;
                res.last0 = 1'b0;
            end else begin
                res.count = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_pending_reg <= 2'd0;
            partial_code_reg  <= '0;
        end else if (fire) begin
            bytes_pending_reg <= bytes_pending_next;
            partial_code_reg  <= partial_code_next;
        end
    end

    `U8SD_ASSERT(a_idle_clear, (bytes_pending_reg != 2'd0 || partial_code_reg == '0), "partial code left over with no sequence open")
    `U8SD_ASSERT(a_pair_first, (res.count == 2'd2 |-> (res.code0 == utf8sd_pkg::REPLACEMENT && !res.last0)), "bad first result of a pair")
    `U8SD_ASSERT(a_hold_state, (!fire |=> ($stable(bytes_pending_reg) && $stable(partial_code_reg))), "state moved without an item")

endmodule

>>> rtl/core/utf8sd_out_fifo.sv
// ----------------------------------------------------------------------------
// utf8sd_out_fifo
// Result queue taking up to two results per cycle, one out per cycle while m_ready is high.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_assert.svh"

module utf8sd_out_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  utf8sd_pkg::dec_res_t res,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          m_code_point,
    output logic                 m_last_of_run
);

    localparam int PW = utf8sd_pkg::PTR_W;
    localparam int CW = utf8sd_pkg::CNT_W;

    logic [15:0]   code_reg [utf8sd_pkg::FIFO_DEPTH];
    logic          last_reg [utf8sd_pkg::FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_b;
    logic [1:0]    push_cnt;
    logic          pop;

    assign push_cnt = push ? res.count : 2'd0;
    assign pop      = m_valid && m_ready;
    assign wr_ptr_b = PW'(wr_ptr_reg + 1'b1);
    assign room     = count_reg <= CW'(utf8sd_pkg::FIFO_DEPTH - 2);

    assign m_valid       = count_reg != '0;
    assign m_code_point  = code_reg[rd_ptr_reg];
    assign m_last_of_run = last_reg[rd_ptr_reg];

    assign wr_ptr_next = PW'(wr_ptr_reg + PW'(push_cnt));
    assign rd_ptr_next = pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
    assign count_next  = CW'(count_reg + CW'(push_cnt) - CW'(pop));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            code_reg[wr_ptr_reg] <= res.code0;
            last_reg[wr_ptr_reg] <= (push_cnt == 2'd1) ? 1'b1 : res.last0;
        end
        if (push_cnt == 2'd2) begin
            code_reg[wr_ptr_b] <= res.code1;
            last_reg[wr_ptr_b] <= 1'b1;
        end
    end

    `U8SD_ASSERT(a_no_overflow, (count_reg <= CW'(utf8sd_pkg::FIFO_DEPTH)), "result queue overflow")
    `U8SD_ASSERT(a_push_room, (push_cnt != 2'd0 |-> room), "push without room")
    `U8SD_ASSERT(a_count_drop, ((pop && push_cnt == 2'd0) |=> count_reg == CW'($past(count_reg) - 1'b1)), "count did not drop on pop")

endmodule

>>> rtl/core/utf8_stream_decoder.sv
// A byte's results pass through the input register and then the result queue on their way out.
// Throughput: one byte per cycle while the queue has room; a byte may give two results.
// The 4-entry result queue takes a byte whenever it holds two or fewer results.
// Reset: synchronous active-low aresetn closes any open sequence and empties all queues.
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to 16-bit code point decoder, top level.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_point,
    output logic        m_last_of_run
);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 room;
    logic                 fire;
    utf8sd_pkg::dec_res_t res;

    assign fire          = in_valid_reg && room;
    assign s_ready       = !in_valid_reg || fire;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    utf8sd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .res     (res)
    );

    utf8sd_out_fifo u_out_fifo (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (fire),
        .res           (res),
        .room          (room),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_point  (m_code_point),
        .m_last_of_run (m_last_of_run)
    );

    `U8SD_ASSERT(a_hold_byte, ((in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_byte_reg))), "stalled item lost")
    `U8SD_ASSERT(a_ready_room, ((in_valid_reg && room) |-> s_ready), "ready low with room")

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives utf8_stream_decoder with a byte stream through valid/ready on both
// sides. Each accepted byte is decoded in a scoreboard, and every result item
// is checked against the oldest expected code point. The stream has directed
// corner bytes first, then mostly well-formed characters with random content,
// mixed with noise, broken sequences and zero bytes that cut a sequence short.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] code;
        logic        last;
    } code_item_t;

    class decoder_scoreboard;
        logic [1:0]         conts_left;
        utf8sd_pkg::part_t  acc;
        code_item_t         expected_q[$];
        int                 errors;

        function new();
            conts_left = 2'd0;
            acc        = '0;
            errors     = 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function logic [15:0] bmp_or_repl(input utf8sd_pkg::part_t v);
            return (v < utf8sd_pkg::CODE_LIMIT) ? v[15:0] : utf8sd_pkg::REPLACEMENT;
        endfunction

        function void push_code(input logic [15:0] cp, input logic last);
            code_item_t e;
            e.code = cp;
            e.last = last;
            expected_q.push_back(e);
        endfunction

        // Returns 1 when the byte emits at once, else opens a sequence.
        function bit decode_lead(input logic [7:0] b, output logic [15:0] cp);
            cp = utf8sd_pkg::REPLACEMENT;
            if (b < utf8sd_pkg::ASCII_END) begin
                cp = {8'h00, b};
                return 1'b1;
            end
            if (b < utf8sd_pkg::LEAD2_FIRST || b >= utf8sd_pkg::LEAD_END) begin
                return 1'b1;
            end
            if (b < utf8sd_pkg::LEAD3_FIRST) begin
                conts_left = 2'd1;
                acc = {16'h0000, b[4:0]};
            end else if (b < utf8sd_pkg::LEAD4_FIRST) begin
                conts_left = 2'd2;
                acc = {17'h00000, b[3:0]};
            end else begin
                conts_left = 2'd3;
                acc = {18'h00000, b[2:0]};
            end
            return 1'b0;
        endfunction

        function void note_byte(input logic [7:0] b);
            logic [15:0] cp;
            if (conts_left == 2'd0) begin
                if (decode_lead(b, cp)) push_code(cp, 1'b1);
            end else if (b == 8'h00) begin
                push_code(bmp_or_repl(acc), 1'b1);
                conts_left = 2'd0;
                acc = '0;
            end else if (b[7:6] == utf8sd_pkg::CONT_TAG) begin
                acc = {acc[14:0], b[5:0]};
                conts_left = conts_left - 2'd1;
                if (conts_left == 2'd0) begin
                    push_code(bmp_or_repl(acc), 1'b1);
                    acc = '0;
                end
            end else begin
                // broken sequence: replace it, then take the byte as a new lead
                conts_left = 2'd0;
                acc = '0;
                if (decode_lead(b, cp)) begin
                    push_code(utf8sd_pkg::REPLACEMENT, 1'b0);
                    push_code(cp, 1'b1);
                end else begin
                    push_code(utf8sd_pkg::REPLACEMENT, 1'b1);
                end
            end
        endfunction

        function void check_result(input logic [15:0] cp, input logic last);
            code_item_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected item: code_point %h last_of_run %b", cp, last);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (cp !== e.code) begin
                $error("code_point mismatch: expected %h, actual %h", e.code, cp);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_of_run mismatch: expected %b, actual %b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int RANDOM_BYTES = 1400;
    localparam int STALL_AT     = 400;
    localparam int DRAIN_AT     = 800;
    localparam int STEADY_AT    = 1200;
    localparam int STALL_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_code_point;
    logic        m_last_of_run;

    decoder_scoreboard sb;
    int  bytes_sent;
    bit  stall_sink;
    bit  steady_tail;

    utf8_stream_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_point  (m_code_point),
        .m_last_of_run (m_last_of_run)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_code_point, m_last_of_run);
        end
    end

    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_sink) begin
                m_ready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge aclk);
                stall_sink = 1'b0;
            end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 11);
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b);
        bit drain;
        bit gap;
        int n;
        drain = (bytes_sent == DRAIN_AT);
        gap   = !steady_tail && ($urandom_range(0, 7) == 0);
        if (bytes_sent == STALL_AT) stall_sink = 1'b1;
        if (bytes_sent == STEADY_AT) steady_tail = 1'b1;
        if (drain || gap) begin
            s_valid <= 1'b0;
            if (drain) begin
                do @(negedge aclk); while (sb.outstanding() > 0);
            end
            if (gap) begin
                n = $urandom_range(1, 11);
                repeat (n) @(negedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            2: return 8'($urandom_range(8'hc2, 8'hdf));
            3: return 8'($urandom_range(8'he0, 8'hef));
            default: return 8'($urandom_range(8'hf0, 8'hf4));
        endcase
    endfunction

    task automatic send_random_char();
        int kind;
        int len;
        int k;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(1, 4);
        if (kind < 65) begin
            if (len == 1) begin
                send_byte(8'($urandom_range(0, 127)));
            end else begin
                send_byte(lead_byte(len));
                repeat (len - 1) send_byte(cont_byte());
            end
        end else if (kind < 75) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (kind < 94) begin
            // cut a sequence short, by a foreign byte or by a zero byte
            len = $urandom_range(2, 4);
            k = $urandom_range(0, len - 2);
            send_byte(lead_byte(len));
            repeat (k) send_byte(cont_byte());
            if (kind < 87) begin
                b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 127))
                                                : 8'($urandom_range(8'hc0, 8'hff));
                send_byte(b);
            end else begin
                send_byte(8'h00);
            end
        end else begin
            b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'hc1))
                                            : 8'($urandom_range(8'hf5, 8'hff));
            send_byte(b);
        end
    endtask

    initial begin
        logic [7:0] corner_bytes [$];
        sb          = new();
        bytes_sent  = 0;
        stall_sink  = 1'b0;
        steady_tail = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_in_byte   = 8'h00;
        corner_bytes = {
            8'h00, 8'h7f, 8'h80, 8'hff, 8'hc1, 8'hf5,
            8'hc2, 8'h80,
            8'hef, 8'hbf, 8'hbf,
            8'hf4, 8'h8f, 8'hbf, 8'hbf,
            8'hc3, 8'h41,
            8'he2, 8'hc3, 8'ha9,
            8'he2, 8'h82, 8'h00,
            8'hf0, 8'h00
        };
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        foreach (corner_bytes[i]) send_byte(corner_bytes[i]);
        while (bytes_sent < RANDOM_BYTES) send_random_char();
        s_valid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/utf8sd_pkg.sv
rtl/core/utf8sd_decode.sv
rtl/core/utf8sd_out_fifo.sv
rtl/core/utf8_stream_decoder.sv
sim/tb.sv
